### rtl/core/teg_pkg.sv
package teg_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 16;

  // sample count registers are always this wide
  localparam int CNT_CFG_W = 24;

  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 3;
  localparam int APB_AW    = REG_IDX_W + 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DELAY        = 3'd0,
    REG_ATTACK       = 3'd1,
    REG_HOLD         = 3'd2,
    REG_HOLD_TGT     = 3'd3,
    REG_ATTACK_COEF  = 3'd4,
    REG_DECAY_COEF   = 3'd5,
    REG_RELEASE_COEF = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_WAITING  = 2'd1,
    PH_ATTACK   = 2'd2,
    PH_HOLD     = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    TGT_ZERO = 2'd0,
    TGT_ONE  = 2'd1,
    TGT_HOLD = 2'd2
  } tgt_sel_t;

  typedef enum logic [1:0] {
    COEF_RELEASE = 2'd0,
    COEF_ATTACK  = 2'd1,
    COEF_DECAY   = 2'd2
  } coef_sel_t;

  typedef struct packed {
    tgt_sel_t  tgt_sel;
    coef_sel_t coef_sel;
  } lvl_ctrl_t;

endpackage

### rtl/core/teg_stream_if.sv
interface teg_in_if;
  logic valid;
  logic ready;
  logic trigger;

  modport source (output valid, output trigger, input ready);
  modport sink (input valid, input trigger, output ready);
endinterface

interface teg_out_if import teg_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [FRAC_BITS:0]   envelope;

  modport source (output valid, output envelope, input ready);
  modport sink (input valid, input envelope, output ready);
endinterface

### rtl/core/trigger_envelope_generator.sv
// Delay / attack / hold / release envelope with exponential smoothing. Each input
// word is one sample tick carrying a trigger flag; each tick yields one output word
// with the envelope level in unsigned Q.FRAC_BITS (full scale = 2^FRAC_BITS). The
// block sustains one tick per clock: the whole update (phase step, counter, one
// multiply-add with rounding and clamp) sits between the input register and the
// level/output register, so each result word is offered from the level/output register
// once its input word has passed through both, and a new word can be taken every cycle while out_chan keeps up.
// When a result waits on out_chan, one more word is taken into the input register
// and in_chan.ready then drops until the result is drained.
// Delay, attack and hold lengths are in samples; coefficients are unsigned
// Q.FRAC_BITS values prepared by software. Registers sit at byte offset 4*index
// and should be written while no words are in flight.
module trigger_envelope_generator import teg_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  teg_in_if.sink            in_chan,
  teg_out_if.source         out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [CNT_CFG_W-1:0] delay_samples;
  logic [CNT_CFG_W-1:0] attack_samples;
  logic [CNT_CFG_W-1:0] hold_samples;
  logic [FRAC_BITS:0]   hold_tgt;
  logic [FRAC_BITS+1:0] attack_coef;
  logic [FRAC_BITS+1:0] decay_coef;
  logic [FRAC_BITS+1:0] release_coef;

  logic      in_valid_r, in_valid_nxt;
  logic      trigger_r;
  logic      out_valid_r, out_valid_nxt;
  logic      out_free;
  logic      step;
  logic      in_fire;
  lvl_ctrl_t ctrl;
  logic [FRAC_BITS:0] level;

  teg_cfg_regs #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .delay_samples  (delay_samples),
    .attack_samples (attack_samples),
    .hold_samples   (hold_samples),
    .hold_tgt       (hold_tgt),
    .attack_coef    (attack_coef),
    .decay_coef     (decay_coef),
    .release_coef   (release_coef)
  );

  // output register is free if empty or being drained this cycle
  assign out_free      = !out_valid_r || out_chan.ready;
  assign step          = in_valid_r && out_free;
  assign in_chan.ready = !in_valid_r || out_free;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_fire) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      trigger_r <= in_chan.trigger;
    end
  end

  teg_seq #(
    .COUNT_BITS (COUNT_BITS)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .trigger        (trigger_r),
    .delay_samples  (delay_samples),
    .attack_samples (attack_samples),
    .hold_samples   (hold_samples),
    .ctrl           (ctrl)
  );

  // level register doubles as the output word register
  teg_level #(
    .FRAC_BITS (FRAC_BITS)
  ) u_level (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .ctrl         (ctrl),
    .hold_tgt     (hold_tgt),
    .attack_coef  (attack_coef),
    .decay_coef   (decay_coef),
    .release_coef (release_coef),
    .level        (level)
  );

  assign out_chan.valid    = out_valid_r;
  assign out_chan.envelope = level;

endmodule

### rtl/core/teg_cfg_regs.sv
module teg_cfg_regs import teg_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready,
  output logic [CNT_CFG_W-1:0]  delay_samples,
  output logic [CNT_CFG_W-1:0]  attack_samples,
  output logic [CNT_CFG_W-1:0]  hold_samples,
  output logic [FRAC_BITS:0]    hold_tgt,
  output logic [FRAC_BITS+1:0]  attack_coef,
  output logic [FRAC_BITS+1:0]  decay_coef,
  output logic [FRAC_BITS+1:0]  release_coef
);

  localparam int LVL_W  = FRAC_BITS + 1;
  localparam int COEF_W = FRAC_BITS + 2;
  localparam logic [LVL_W-1:0]  ONE_LVL  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [COEF_W-1:0] ONE_COEF = {2'b01, {FRAC_BITS{1'b0}}};

  logic [CNT_CFG_W-1:0] delay_samples_r;
  logic [CNT_CFG_W-1:0] attack_samples_r;
  logic [CNT_CFG_W-1:0] hold_samples_r;
  logic [LVL_W-1:0]     hold_tgt_r;
  logic [COEF_W-1:0]    attack_coef_r;
  logic [COEF_W-1:0]    decay_coef_r;
  logic [COEF_W-1:0]    release_coef_r;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[APB_AW-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_samples_r  <= '0;
      attack_samples_r <= '0;
      hold_samples_r   <= '0;
      hold_tgt_r       <= ONE_LVL;
      attack_coef_r    <= ONE_COEF;
      decay_coef_r     <= ONE_COEF;
      release_coef_r   <= ONE_COEF;
    end else if (wr_en) begin
      case (idx)
        REG_DELAY:        delay_samples_r  <= pwdata[CNT_CFG_W-1:0];
        REG_ATTACK:       attack_samples_r <= pwdata[CNT_CFG_W-1:0];
        REG_HOLD:         hold_samples_r   <= pwdata[CNT_CFG_W-1:0];
        REG_HOLD_TGT:     hold_tgt_r       <= pwdata[LVL_W-1:0];
        REG_ATTACK_COEF:  attack_coef_r    <= pwdata[COEF_W-1:0];
        REG_DECAY_COEF:   decay_coef_r     <= pwdata[COEF_W-1:0];
        REG_RELEASE_COEF: release_coef_r   <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DELAY:        prdata = APB_DW'(delay_samples_r);
      REG_ATTACK:       prdata = APB_DW'(attack_samples_r);
      REG_HOLD:         prdata = APB_DW'(hold_samples_r);
      REG_HOLD_TGT:     prdata = APB_DW'(hold_tgt_r);
      REG_ATTACK_COEF:  prdata = APB_DW'(attack_coef_r);
      REG_DECAY_COEF:   prdata = APB_DW'(decay_coef_r);
      REG_RELEASE_COEF: prdata = APB_DW'(release_coef_r);
      default:          prdata = '0;
    endcase
  end

  assign delay_samples  = delay_samples_r;
  assign attack_samples = attack_samples_r;
  assign hold_samples   = hold_samples_r;
  assign hold_tgt       = hold_tgt_r;
  assign attack_coef    = attack_coef_r;
  assign decay_coef     = decay_coef_r;
  assign release_coef   = release_coef_r;

endmodule

### rtl/core/teg_seq.sv
module teg_seq import teg_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 trigger,
  input  logic [CNT_CFG_W-1:0] delay_samples,
  input  logic [CNT_CFG_W-1:0] attack_samples,
  input  logic [CNT_CFG_W-1:0] hold_samples,
  output lvl_ctrl_t            ctrl
);

  localparam int CMP_W = (COUNT_BITS > CNT_CFG_W) ? COUNT_BITS : CNT_CFG_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  phase_t                phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] elapsed_r, elapsed_nxt;

  phase_t                ph_cur;
  phase_t                ph_next;
  logic [COUNT_BITS-1:0] el_cur;
  logic [COUNT_BITS-1:0] el_adv;
  logic [CNT_CFG_W-1:0]  limit;
  logic                  advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_RELEASED;
      elapsed_r <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  always_comb begin
    // a trigger restarts, straight into attack when there is no delay
    if (trigger) begin
      ph_cur = (delay_samples == '0) ? PH_ATTACK : PH_WAITING;
      el_cur = '0;
    end else begin
      ph_cur = phase_r;
      el_cur = elapsed_r;
    end

    case (ph_cur)
      PH_WAITING: begin
        ctrl    = '{tgt_sel: TGT_ZERO, coef_sel: COEF_RELEASE};
        limit   = delay_samples;
        ph_next = PH_ATTACK;
      end
      PH_ATTACK: begin
        ctrl    = '{tgt_sel: TGT_ONE, coef_sel: COEF_ATTACK};
        limit   = attack_samples;
        ph_next = PH_HOLD;
      end
      PH_HOLD: begin
        ctrl    = '{tgt_sel: TGT_HOLD, coef_sel: COEF_DECAY};
        limit   = hold_samples;
        ph_next = PH_RELEASED;
      end
      default: begin
        ctrl    = '{tgt_sel: TGT_ZERO, coef_sel: COEF_RELEASE};
        limit   = '0;
        ph_next = PH_RELEASED;
      end
    endcase

    advance = (ph_cur != PH_RELEASED) && (CMP_W'(el_cur) > CMP_W'(limit));

    // target and coef above still belong to the phase being left
    phase_nxt = advance ? ph_next : ph_cur;
    el_adv    = advance ? '0 : el_cur;

    elapsed_nxt = (el_adv < COUNT_MAX) ? el_adv + 1'b1 : el_adv;
  end

endmodule

### rtl/core/teg_level.sv
module teg_level import teg_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  lvl_ctrl_t            ctrl,
  input  logic [FRAC_BITS:0]   hold_tgt,
  input  logic [FRAC_BITS+1:0] attack_coef,
  input  logic [FRAC_BITS+1:0] decay_coef,
  input  logic [FRAC_BITS+1:0] release_coef,
  output logic [FRAC_BITS:0]   level
);

  localparam int LVL_W  = FRAC_BITS + 1;
  localparam int COEF_W = FRAC_BITS + 2;
  localparam int OMC_W  = FRAC_BITS + 3;
  localparam int PL_W   = LVL_W + 1 + OMC_W;
  localparam int PT_W   = LVL_W + COEF_W;
  localparam int SUM_W  = 2 * FRAC_BITS + 6;

  localparam logic [LVL_W-1:0]        ONE_LVL = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [OMC_W-1:0]        ONE_OMC = {3'b001, {FRAC_BITS{1'b0}}};
  localparam logic signed [SUM_W-1:0] HALF_S  = SUM_W'(ONE_LVL >> 1);
  localparam logic signed [SUM_W-1:0] ONE_S   = SUM_W'(ONE_LVL);

  logic [LVL_W-1:0]        level_r, level_nxt;
  logic [LVL_W-1:0]        target;
  logic [COEF_W-1:0]       coef;
  logic signed [OMC_W-1:0] omc;
  logic signed [PL_W-1:0]  p_lvl;
  logic [PT_W-1:0]         p_tgt;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] rounded;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else if (step) begin
      level_r <= level_nxt;
    end
  end

  always_comb begin
    case (ctrl.tgt_sel)
      TGT_ONE:  target = ONE_LVL;
      TGT_HOLD: target = hold_tgt;
      default:  target = '0;
    endcase

    case (ctrl.coef_sel)
      COEF_ATTACK: coef = attack_coef;
      COEF_DECAY:  coef = decay_coef;
      default:     coef = release_coef;
    endcase

    // one minus coef goes negative for coef above one
    omc   = $signed(ONE_OMC - {1'b0, coef});
    p_lvl = $signed({1'b0, level_r}) * omc;
    p_tgt = target * coef;

    sum     = SUM_W'(p_lvl) + $signed(SUM_W'(p_tgt));
    rounded = (sum + HALF_S) >>> FRAC_BITS;

    if (sum <= 0) begin
      level_nxt = '0;
    end else if (rounded > ONE_S) begin
      level_nxt = ONE_LVL;
    end else begin
      level_nxt = rounded[LVL_W-1:0];
    end
  end

  assign level = level_r;

endmodule
